@@ src/qte_pkg.sv @@
package qte_pkg;

    // number formats
    localparam int FRAC_BITS = 16;
    localparam int S_FRAC    = 30;
    localparam int W         = 64;
    localparam int DIV_BITS  = W + S_FRAC;
    localparam int DCNT_W    = $clog2(DIV_BITS + 2);
    localparam int PC_W      = 7;
    localparam int SLOT_W    = 6;
    localparam int NSLOT     = 1 << SLOT_W;

    localparam logic [30:0] DUR_RESET = 31'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_P0  = 3'd0;
    localparam logic [2:0] CFG_V0  = 3'd1;
    localparam logic [2:0] CFG_A0  = 3'd2;
    localparam logic [2:0] CFG_P1  = 3'd3;
    localparam logic [2:0] CFG_V1  = 3'd4;
    localparam logic [2:0] CFG_A1  = 3'd5;
    localparam logic [2:0] CFG_DUR = 3'd6;

    // register file slots
    localparam logic [5:0] R_CA    = 6'd0;
    localparam logic [5:0] R_CB    = 6'd1;
    localparam logic [5:0] R_CC    = 6'd2;
    localparam logic [5:0] R_A0    = 6'd3;
    localparam logic [5:0] R_V0    = 6'd4;
    localparam logic [5:0] R_P0    = 6'd5;
    localparam logic [5:0] R_P1    = 6'd6;
    localparam logic [5:0] R_V1    = 6'd7;
    localparam logic [5:0] R_A1    = 6'd8;
    localparam logic [5:0] R_T     = 6'd9;
    localparam logic [5:0] R_VT    = 6'd10;
    localparam logic [5:0] R_AT    = 6'd11;
    localparam logic [5:0] R_ATTH  = 6'd12;
    localparam logic [5:0] R_H0    = 6'd13;
    localparam logic [5:0] R_H1    = 6'd14;
    localparam logic [5:0] R_H2    = 6'd15;
    localparam logic [5:0] R_H1T   = 6'd16;
    localparam logic [5:0] R_H2T   = 6'd17;
    localparam logic [5:0] R_H2TT  = 6'd18;
    localparam logic [5:0] R_H2TTH = 6'd19;
    localparam logic [5:0] R_X     = 6'd20;
    localparam logic [5:0] R_Y     = 6'd21;
    localparam logic [5:0] R_TS    = 6'd22;
    localparam logic [5:0] R_T2    = 6'd23;
    localparam logic [5:0] R_POS   = 6'd24;
    localparam logic [5:0] R_VEL   = 6'd25;
    localparam logic [5:0] R_ACC   = 6'd26;
    localparam logic [5:0] R_JRK   = 6'd27;
    localparam logic [5:0] R_S     = 6'd28;
    localparam logic [5:0] R_S2    = 6'd29;
    localparam logic [5:0] R_S3    = 6'd30;
    localparam logic [5:0] R_S4    = 6'd31;
    localparam logic [5:0] R_S5    = 6'd32;

    // output field indexes, carried in the dst field of OUT
    localparam logic [5:0] OUT_POS = 6'd0;
    localparam logic [5:0] OUT_VEL = 6'd1;
    localparam logic [5:0] OUT_ACC = 6'd2;
    localparam logic [5:0] OUT_JRK = 6'd3;

    // product shifts
    localparam logic [5:0] K_0  = 6'd0;
    localparam logic [5:0] K_F  = 6'(FRAC_BITS);
    localparam logic [5:0] K_F1 = 6'(FRAC_BITS + 1);
    localparam logic [5:0] K_S  = 6'(S_FRAC);

    localparam logic [PC_W-1:0] PC_CFG  = 7'd0;
    localparam logic [PC_W-1:0] PC_EVAL = 7'd36;

    typedef enum logic [3:0] {
        OP_LDI, OP_LDC, OP_LDT, OP_ADD, OP_SUB, OP_MUL, OP_MULI, OP_DIV,
        OP_OUT, OP_CFGEND, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_WAIT} t_state;

    // skz: skipped when the duration is zero
    typedef struct packed {
        t_op               op;
        logic              skz;
        logic [5:0]        dst;
        logic [5:0]        sa;
        logic [5:0]        sb;
        logic [5:0]        k;
        logic signed [31:0] imm;
    } t_instr;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [63:0] res;
    } t_unit_rsp;

    function automatic t_instr ins(input t_op op, input logic skz, input logic [5:0] dst,
                                   input logic [5:0] sa, input logic [5:0] sb,
                                   input logic [5:0] k, input logic signed [31:0] imm);
        t_instr r;
        r.op  = op;
        r.skz = skz;
        r.dst = dst;
        r.sa  = sa;
        r.sb  = sb;
        r.k   = k;
        r.imm = imm;
        return r;
    endfunction

    // microcode: coefficient derivation from PC_CFG, sample evaluation from PC_EVAL
    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr r;
        unique case (pc)
            7'd0:  r = ins(OP_LDC, 1'b0, R_A0, R_A0, R_A0, K_0, 32'(CFG_A0));
            7'd1:  r = ins(OP_LDC, 1'b0, R_V0, R_A0, R_A0, K_0, 32'(CFG_V0));
            7'd2:  r = ins(OP_LDC, 1'b0, R_P0, R_A0, R_A0, K_0, 32'(CFG_P0));
            7'd3:  r = ins(OP_LDC, 1'b0, R_P1, R_A0, R_A0, K_0, 32'(CFG_P1));
            7'd4:  r = ins(OP_LDC, 1'b0, R_V1, R_A0, R_A0, K_0, 32'(CFG_V1));
            7'd5:  r = ins(OP_LDC, 1'b0, R_A1, R_A0, R_A0, K_0, 32'(CFG_A1));
            7'd6:  r = ins(OP_LDC, 1'b0, R_T,  R_A0, R_A0, K_0, 32'(CFG_DUR));
            7'd7:  r = ins(OP_LDI, 1'b0, R_CA, R_A0, R_A0, K_0, 32'sd0);
            7'd8:  r = ins(OP_LDI, 1'b0, R_CB, R_A0, R_A0, K_0, 32'sd0);
            7'd9:  r = ins(OP_LDI, 1'b0, R_CC, R_A0, R_A0, K_0, 32'sd0);
            7'd10: r = ins(OP_MUL, 1'b1, R_VT, R_V0, R_T, K_F, 32'sd0);
            7'd11: r = ins(OP_MUL, 1'b1, R_AT, R_A0, R_T, K_F, 32'sd0);
            7'd12: r = ins(OP_MUL, 1'b1, R_ATTH, R_AT, R_T, K_F1, 32'sd0);
            7'd13: r = ins(OP_SUB, 1'b1, R_X, R_P1, R_P0, K_0, 32'sd0);
            7'd14: r = ins(OP_SUB, 1'b1, R_X, R_X, R_VT, K_0, 32'sd0);
            7'd15: r = ins(OP_SUB, 1'b1, R_H0, R_X, R_ATTH, K_0, 32'sd0);
            7'd16: r = ins(OP_SUB, 1'b1, R_X, R_V1, R_V0, K_0, 32'sd0);
            7'd17: r = ins(OP_SUB, 1'b1, R_H1, R_X, R_AT, K_0, 32'sd0);
            7'd18: r = ins(OP_SUB, 1'b1, R_H2, R_A1, R_A0, K_0, 32'sd0);
            7'd19: r = ins(OP_MUL, 1'b1, R_H1T, R_H1, R_T, K_F, 32'sd0);
            7'd20: r = ins(OP_MUL, 1'b1, R_H2T, R_H2, R_T, K_F, 32'sd0);
            7'd21: r = ins(OP_MUL, 1'b1, R_H2TT, R_H2T, R_T, K_F, 32'sd0);
            7'd22: r = ins(OP_MUL, 1'b1, R_H2TTH, R_H2T, R_T, K_F1, 32'sd0);
            7'd23: r = ins(OP_MULI, 1'b1, R_X, R_H0, R_A0, K_0, 32'sd6);
            7'd24: r = ins(OP_MULI, 1'b1, R_Y, R_H1T, R_A0, K_0, 32'sd3);
            7'd25: r = ins(OP_SUB, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd26: r = ins(OP_ADD, 1'b1, R_CA, R_X, R_H2TTH, K_0, 32'sd0);
            7'd27: r = ins(OP_MULI, 1'b1, R_X, R_H0, R_A0, K_0, -32'sd15);
            7'd28: r = ins(OP_MULI, 1'b1, R_Y, R_H1T, R_A0, K_0, 32'sd7);
            7'd29: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd30: r = ins(OP_SUB, 1'b1, R_CB, R_X, R_H2TT, K_0, 32'sd0);
            7'd31: r = ins(OP_MULI, 1'b1, R_X, R_H0, R_A0, K_0, 32'sd10);
            7'd32: r = ins(OP_MULI, 1'b1, R_Y, R_H1T, R_A0, K_0, 32'sd4);
            7'd33: r = ins(OP_SUB, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd34: r = ins(OP_ADD, 1'b1, R_CC, R_X, R_H2TTH, K_0, 32'sd0);
            7'd35: r = ins(OP_CFGEND, 1'b0, R_A0, R_A0, R_A0, K_0, 32'sd0);
            // evaluation: polynomial in t
            7'd36: r = ins(OP_LDT, 1'b0, R_TS, R_A0, R_A0, K_0, 32'sd0);
            7'd37: r = ins(OP_MUL, 1'b0, R_T2, R_TS, R_TS, K_F, 32'sd0);
            7'd38: r = ins(OP_MUL, 1'b0, R_X, R_V0, R_TS, K_F, 32'sd0);
            7'd39: r = ins(OP_ADD, 1'b0, R_X, R_P0, R_X, K_0, 32'sd0);
            7'd40: r = ins(OP_MUL, 1'b0, R_Y, R_A0, R_T2, K_F1, 32'sd0);
            7'd41: r = ins(OP_ADD, 1'b0, R_POS, R_X, R_Y, K_0, 32'sd0);
            7'd42: r = ins(OP_MUL, 1'b0, R_X, R_A0, R_TS, K_F, 32'sd0);
            7'd43: r = ins(OP_ADD, 1'b0, R_VEL, R_V0, R_X, K_0, 32'sd0);
            7'd44: r = ins(OP_LDI, 1'b0, R_JRK, R_A0, R_A0, K_0, 32'sd0);
            7'd45: r = ins(OP_ADD, 1'b0, R_ACC, R_A0, R_JRK, K_0, 32'sd0);
            // normalized time terms
            7'd46: r = ins(OP_DIV, 1'b1, R_S, R_TS, R_A0, K_S, 32'sd0);
            7'd47: r = ins(OP_MUL, 1'b1, R_S2, R_S, R_S, K_S, 32'sd0);
            7'd48: r = ins(OP_MUL, 1'b1, R_S3, R_S2, R_S, K_S, 32'sd0);
            7'd49: r = ins(OP_MUL, 1'b1, R_S4, R_S3, R_S, K_S, 32'sd0);
            7'd50: r = ins(OP_MUL, 1'b1, R_S5, R_S4, R_S, K_S, 32'sd0);
            7'd51: r = ins(OP_MUL, 1'b1, R_X, R_CA, R_S5, K_S, 32'sd0);
            7'd52: r = ins(OP_MUL, 1'b1, R_Y, R_CB, R_S4, K_S, 32'sd0);
            7'd53: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd54: r = ins(OP_MUL, 1'b1, R_Y, R_CC, R_S3, K_S, 32'sd0);
            7'd55: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd56: r = ins(OP_ADD, 1'b1, R_POS, R_POS, R_X, K_0, 32'sd0);
            7'd57: r = ins(OP_MULI, 1'b1, R_X, R_CA, R_A0, K_0, 32'sd5);
            7'd58: r = ins(OP_MUL, 1'b1, R_X, R_X, R_S4, K_S, 32'sd0);
            7'd59: r = ins(OP_MULI, 1'b1, R_Y, R_CB, R_A0, K_0, 32'sd4);
            7'd60: r = ins(OP_MUL, 1'b1, R_Y, R_Y, R_S3, K_S, 32'sd0);
            7'd61: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd62: r = ins(OP_MULI, 1'b1, R_Y, R_CC, R_A0, K_0, 32'sd3);
            7'd63: r = ins(OP_MUL, 1'b1, R_Y, R_Y, R_S2, K_S, 32'sd0);
            7'd64: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd65: r = ins(OP_DIV, 1'b1, R_X, R_X, R_A0, K_F, 32'sd0);
            7'd66: r = ins(OP_ADD, 1'b1, R_VEL, R_VEL, R_X, K_0, 32'sd0);
            7'd67: r = ins(OP_MULI, 1'b1, R_X, R_CA, R_A0, K_0, 32'sd20);
            7'd68: r = ins(OP_MUL, 1'b1, R_X, R_X, R_S3, K_S, 32'sd0);
            7'd69: r = ins(OP_MULI, 1'b1, R_Y, R_CB, R_A0, K_0, 32'sd12);
            7'd70: r = ins(OP_MUL, 1'b1, R_Y, R_Y, R_S2, K_S, 32'sd0);
            7'd71: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd72: r = ins(OP_MULI, 1'b1, R_Y, R_CC, R_A0, K_0, 32'sd6);
            7'd73: r = ins(OP_MUL, 1'b1, R_Y, R_Y, R_S, K_S, 32'sd0);
            7'd74: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd75: r = ins(OP_DIV, 1'b1, R_X, R_X, R_A0, K_F, 32'sd0);
            7'd76: r = ins(OP_DIV, 1'b1, R_X, R_X, R_A0, K_F, 32'sd0);
            7'd77: r = ins(OP_ADD, 1'b1, R_ACC, R_ACC, R_X, K_0, 32'sd0);
            7'd78: r = ins(OP_MULI, 1'b1, R_X, R_CA, R_A0, K_0, 32'sd60);
            7'd79: r = ins(OP_MUL, 1'b1, R_X, R_X, R_S2, K_S, 32'sd0);
            7'd80: r = ins(OP_MULI, 1'b1, R_Y, R_CB, R_A0, K_0, 32'sd24);
            7'd81: r = ins(OP_MUL, 1'b1, R_Y, R_Y, R_S, K_S, 32'sd0);
            7'd82: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd83: r = ins(OP_MULI, 1'b1, R_Y, R_CC, R_A0, K_0, 32'sd6);
            7'd84: r = ins(OP_ADD, 1'b1, R_X, R_X, R_Y, K_0, 32'sd0);
            7'd85: r = ins(OP_DIV, 1'b1, R_X, R_X, R_A0, K_F, 32'sd0);
            7'd86: r = ins(OP_DIV, 1'b1, R_X, R_X, R_A0, K_F, 32'sd0);
            7'd87: r = ins(OP_DIV, 1'b1, R_JRK, R_X, R_A0, K_F, 32'sd0);
            // clamp and deliver
            7'd88: r = ins(OP_OUT, 1'b0, OUT_POS, R_POS, R_A0, K_0, 32'sd0);
            7'd89: r = ins(OP_OUT, 1'b0, OUT_VEL, R_VEL, R_A0, K_0, 32'sd0);
            7'd90: r = ins(OP_OUT, 1'b0, OUT_ACC, R_ACC, R_A0, K_0, 32'sd0);
            7'd91: r = ins(OP_OUT, 1'b0, OUT_JRK, R_JRK, R_A0, K_0, 32'sd0);
            7'd92: r = ins(OP_EMIT, 1'b0, R_A0, R_A0, R_A0, K_0, 32'sd0);
            default: r = ins(OP_EMIT, 1'b0, R_A0, R_A0, R_A0, K_0, 32'sd0);
        endcase
        return r;
    endfunction

endpackage

@@ src/qte_fifo.sv @@
// two-entry sample-time queue in front of the engine
module qte_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic signed [31:0] i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_avail,
    output logic signed [31:0] o_data
);

    logic signed [31:0] r_mem [0:1];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               n_wp;
    logic               n_rp;
    logic [1:0]         n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ src/qte_mul.sv @@
// signed 64x64 product, shifted right by k with rounding half away from zero,
// saturated to +-(2^63-1); four 32x32 partials, one a cycle
module qte_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic [5:0]         i_k,
    output qte_pkg::t_unit_rsp o_rsp
);

    localparam logic [2:0] CNT_RND  = 3'd4;
    localparam logic [2:0] CNT_DONE = 3'd5;

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [5:0]   r_k;
    logic [127:0] r_acc;

    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [63:0]  w_pp;
    logic [7:0]   w_sh;
    logic [127:0] w_rnd;
    logic [63:0]  w_mag;

    // partial product select
    always_comb begin
        w_pa  = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        w_pb  = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        w_pp  = 64'(w_pa) * 64'(w_pb);
        w_sh  = {1'b0, r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0], 5'b0};
        w_rnd = (r_k == 6'd0) ? 128'd0 : (128'd1 << (r_k - 6'd1));
    end

    // result
    always_comb begin
        o_rsp.done = r_busy && (r_cnt == CNT_DONE);
        o_rsp.sat  = |r_acc[127:63];
        w_mag      = o_rsp.sat ? 64'(qte_pkg::S64_MAX) : r_acc[63:0];
        o_rsp.res  = r_neg ? -$signed(w_mag) : $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_DONE);
            r_cnt  <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_k   <= i_k;
            r_acc <= 128'd0;
        end else if (r_busy && r_cnt < CNT_RND) begin
            r_acc <= r_acc + (128'(w_pp) << w_sh);
        end else if (r_busy && r_cnt == CNT_RND) begin
            r_acc <= (r_acc + w_rnd) >> r_k;
        end
    end

endmodule

@@ src/qte_div.sv @@
// (|x| << k) / d, one quotient bit a cycle, rounded half away from zero,
// sign restored and saturated to +-(2^63-1)
module qte_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_x,
    input  logic [5:0]         i_k,
    input  logic [30:0]        i_d,
    output qte_pkg::t_unit_rsp o_rsp
);

    localparam int NB = qte_pkg::DIV_BITS;
    localparam int CW = qte_pkg::DCNT_W;
    localparam logic [CW-1:0] CNT_RND  = CW'(NB);
    localparam logic [CW-1:0] CNT_DONE = CW'(NB + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NB-1:0] r_num;
    logic [NB:0]   r_q;
    logic [31:0]   r_rem;
    logic [30:0]   r_d;
    logic          r_neg;

    logic [63:0]   w_mx;
    logic [31:0]   w_cur;
    logic          w_ge;
    logic          w_up;
    logic [63:0]   w_mag;

    // one restoring step
    always_comb begin
        w_mx  = i_x[63] ? 64'(-i_x) : 64'(i_x);
        w_cur = {r_rem[30:0], r_num[NB-1]};
        w_ge  = (w_cur >= {1'b0, r_d});
        w_up  = ({r_rem[30:0], 1'b0} >= {1'b0, r_d});
    end

    always_comb begin
        o_rsp.done = r_busy && (r_cnt == CNT_DONE);
        o_rsp.sat  = |r_q[NB:63];
        w_mag      = o_rsp.sat ? 64'(qte_pkg::S64_MAX) : r_q[63:0];
        o_rsp.res  = r_neg ? -$signed(w_mag) : $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_DONE);
            r_cnt  <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NB'({{qte_pkg::S_FRAC{1'b0}}, w_mx} << i_k);
            r_rem <= 32'd0;
            r_d   <= i_d;
            r_neg <= i_x[63];
        end else if (r_busy && r_cnt < CNT_RND) begin
            r_rem <= w_ge ? (w_cur - {1'b0, r_d}) : w_cur;
            r_num <= {r_num[NB-2:0], w_ge};
        end else if (r_busy && r_cnt == CNT_RND) begin
            r_q <= {1'b0, r_num} + (NB+1)'(w_up);
        end
    end

endmodule

@@ src/qte_engine.sv @@
// back end: configuration registers, register file and microcoded sequencer
// driving the shared multiply and divide units
module qte_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_avail,
    input  logic signed [31:0] i_ts,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [31:0] o_pos,
    output logic signed [31:0] o_vel,
    output logic signed [31:0] o_acc,
    output logic signed [31:0] o_jrk,
    output logic               o_ovf,
    output logic               o_sing
);

    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
    localparam logic signed [63:0] O32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] O32_MIN = -64'sh0000_0000_8000_0000;

    qte_pkg::t_state r_state;
    qte_pkg::t_state n_state;

    logic [31:0]                 r_cfg [0:5];
    logic [30:0]                 r_dur;
    logic signed [63:0]          r_rf [0:qte_pkg::NSLOT-1];
    logic signed [63:0]          r_rda;
    logic signed [63:0]          r_rdb;
    logic [qte_pkg::PC_W-1:0]    r_pc;
    logic [qte_pkg::PC_W-1:0]    n_pc;
    logic                        r_pend;
    logic                        n_pend;
    logic                        r_sat;
    logic                        n_sat;
    logic                        r_coef_sat;
    logic                        n_coef_sat;
    logic signed [31:0]          r_ts;
    logic                        r_is_div;
    logic                        r_valid;
    logic                        n_valid;
    logic signed [31:0]          r_out [0:3];
    logic                        r_ovf;
    logic                        r_sing;

    qte_pkg::t_instr             w_ins;
    qte_pkg::t_unit_rsp          w_mul_rsp;
    qte_pkg::t_unit_rsp          w_div_rsp;
    qte_pkg::t_unit_rsp          w_rsp;
    logic                        w_skip;
    logic                        w_dur_zero;
    logic                        w_cfg_ok;
    logic                        w_take_cfg;
    logic                        w_take_item;
    logic                        w_mul_start;
    logic                        w_div_start;
    logic signed [63:0]          w_mb;
    logic [5:0]                  w_mk;
    logic                        w_we;
    logic signed [63:0]          w_wdata;
    logic signed [63:0]          w_ldc;
    logic signed [64:0]          w_sum;
    logic signed [63:0]          w_sum_c;
    logic                        w_sum_sat;
    logic signed [31:0]          w_o32;
    logic                        w_o32_sat;
    logic                        w_out_we;

    assign w_ins       = qte_pkg::prog(r_pc);
    assign w_dur_zero  = (r_dur == 31'd0);
    assign w_skip      = w_ins.skz && w_dur_zero;
    assign w_cfg_ok    = (i_cfg_idx <= qte_pkg::CFG_DUR);
    assign w_take_cfg  = (r_state == qte_pkg::ST_IDLE) && r_pend;
    assign w_take_item = (r_state == qte_pkg::ST_IDLE) && !r_pend && i_avail;
    assign w_rsp       = r_is_div ? w_div_rsp : w_mul_rsp;

    // configuration register read for LDC
    always_comb begin
        if (w_ins.imm[2:0] == qte_pkg::CFG_DUR || w_ins.imm[2:0] > qte_pkg::CFG_DUR) begin
            w_ldc = 64'(r_dur);
        end else begin
            w_ldc = 64'($signed(r_cfg[w_ins.imm[2:0]]));
        end
    end

    // saturating add and subtract
    always_comb begin
        if (w_ins.op == qte_pkg::OP_SUB) begin
            w_sum = {r_rda[63], r_rda} - {r_rdb[63], r_rdb};
        end else begin
            w_sum = {r_rda[63], r_rda} + {r_rdb[63], r_rdb};
        end
        w_sum_sat = (w_sum > SUM_MAX) || (w_sum < SUM_MIN);
        if (w_sum > SUM_MAX) begin
            w_sum_c = qte_pkg::S64_MAX;
        end else if (w_sum < SUM_MIN) begin
            w_sum_c = -qte_pkg::S64_MAX;
        end else begin
            w_sum_c = w_sum[63:0];
        end
    end

    // 32-bit output clamp
    always_comb begin
        w_o32_sat = (r_rda > O32_MAX) || (r_rda < O32_MIN);
        if (r_rda > O32_MAX) begin
            w_o32 = 32'sh7FFF_FFFF;
        end else if (r_rda < O32_MIN) begin
            w_o32 = -32'sh7FFF_FFFF - 32'sd1;
        end else begin
            w_o32 = r_rda[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qte_pkg::ST_IDLE: begin
                if (r_pend || i_avail) begin
                    n_state = qte_pkg::ST_READ;
                end
            end
            qte_pkg::ST_READ: begin
                n_state = w_skip ? qte_pkg::ST_READ : qte_pkg::ST_EXEC;
            end
            qte_pkg::ST_EXEC: begin
                unique case (w_ins.op)
                    qte_pkg::OP_MUL, qte_pkg::OP_MULI, qte_pkg::OP_DIV:
                        n_state = qte_pkg::ST_WAIT;
                    qte_pkg::OP_CFGEND, qte_pkg::OP_EMIT:
                        n_state = qte_pkg::ST_IDLE;
                    default:
                        n_state = qte_pkg::ST_READ;
                endcase
            end
            qte_pkg::ST_WAIT: begin
                if (w_rsp.done) begin
                    n_state = qte_pkg::ST_READ;
                end
            end
            default: n_state = qte_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    always_comb begin
        n_pc        = r_pc;
        n_sat       = r_sat;
        n_coef_sat  = r_coef_sat;
        n_pend      = r_pend || (i_cfg_we && w_cfg_ok);
        n_valid     = 1'b0;
        w_we        = 1'b0;
        w_wdata     = w_sum_c;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mb        = r_rdb;
        w_mk        = w_ins.k;
        w_out_we    = 1'b0;
        o_pop       = w_take_item;
        if (w_take_cfg) begin
            n_pc   = qte_pkg::PC_CFG;
            n_sat  = 1'b0;
            n_pend = i_cfg_we && w_cfg_ok;
        end else if (w_take_item) begin
            n_pc  = qte_pkg::PC_EVAL;
            n_sat = r_coef_sat;
        end
        unique case (r_state)
            qte_pkg::ST_READ: begin
                if (w_skip) begin
                    n_pc = r_pc + 7'd1;
                end
            end
            qte_pkg::ST_EXEC: begin
                n_pc = r_pc + 7'd1;
                unique case (w_ins.op)
                    qte_pkg::OP_LDI: begin
                        w_we    = 1'b1;
                        w_wdata = 64'(w_ins.imm);
                    end
                    qte_pkg::OP_LDC: begin
                        w_we    = 1'b1;
                        w_wdata = w_ldc;
                    end
                    qte_pkg::OP_LDT: begin
                        w_we    = 1'b1;
                        w_wdata = 64'(r_ts);
                    end
                    qte_pkg::OP_ADD, qte_pkg::OP_SUB: begin
                        w_we  = 1'b1;
                        n_sat = r_sat | w_sum_sat;
                    end
                    // unit ops hold the pc so the write-back sees their destination
                    qte_pkg::OP_MUL: begin
                        n_pc        = r_pc;
                        w_mul_start = 1'b1;
                    end
                    qte_pkg::OP_MULI: begin
                        n_pc        = r_pc;
                        w_mul_start = 1'b1;
                        w_mb        = 64'(w_ins.imm);
                    end
                    qte_pkg::OP_DIV: begin
                        n_pc        = r_pc;
                        w_div_start = 1'b1;
                    end
                    qte_pkg::OP_OUT: begin
                        w_out_we = 1'b1;
                        n_sat    = r_sat | w_o32_sat;
                    end
                    qte_pkg::OP_CFGEND: begin
                        n_coef_sat = r_sat;
                    end
                    qte_pkg::OP_EMIT: begin
                        n_valid = 1'b1;
                    end
                    default: begin
                        n_pc = r_pc + 7'd1;
                    end
                endcase
            end
            qte_pkg::ST_WAIT: begin
                if (w_rsp.done) begin
                    n_pc    = r_pc + 7'd1;
                    w_we    = 1'b1;
                    w_wdata = w_rsp.res;
                    n_sat   = r_sat | w_rsp.sat;
                end
            end
            default: begin
                n_pc = n_pc;
            end
        endcase
    end

    qte_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_rda),
        .i_b     (w_mb),
        .i_k     (w_mk),
        .o_rsp   (w_mul_rsp)
    );

    qte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_x     (r_rda),
        .i_k     (w_mk),
        .i_d     (r_dur),
        .o_rsp   (w_div_rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= qte_pkg::ST_IDLE;
            r_pc       <= qte_pkg::PC_CFG;
            r_pend     <= 1'b1;
            r_sat      <= 1'b0;
            r_coef_sat <= 1'b0;
            r_valid    <= 1'b0;
            r_is_div   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pc       <= n_pc;
            r_pend     <= n_pend;
            r_sat      <= n_sat;
            r_coef_sat <= n_coef_sat;
            r_valid    <= n_valid;
            if (w_mul_start || w_div_start) begin
                r_is_div <= w_div_start;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_cfg[i] <= 32'd0;
            end
            r_dur <= qte_pkg::DUR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == qte_pkg::CFG_DUR) begin
                r_dur <= i_cfg_data[30:0];
            end else if (i_cfg_idx < qte_pkg::CFG_DUR) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // register file, registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_rf[w_ins.dst] <= w_wdata;
        end
        r_rda <= r_rf[w_ins.sa];
        r_rdb <= r_rf[w_ins.sb];
    end

    // item latch and result registers
    always_ff @(posedge i_clk) begin
        if (w_take_item) begin
            r_ts <= i_ts;
        end
        if (w_out_we) begin
            r_out[w_ins.dst[1:0]] <= w_o32;
        end
        if (n_valid) begin
            r_ovf  <= r_sat;
            r_sing <= w_dur_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_pos   = r_out[qte_pkg::OUT_POS[1:0]];
    assign o_vel   = r_out[qte_pkg::OUT_VEL[1:0]];
    assign o_acc   = r_out[qte_pkg::OUT_ACC[1:0]];
    assign o_jrk   = r_out[qte_pkg::OUT_JRK[1:0]];
    assign o_ovf   = r_ovf;
    assign o_sing  = r_sing;

endmodule

@@ src/quintic_trajectory_evaluator.sv @@
// Channel   Direction  Handshake                 Payload
// item      in         start & !busy             i_sample_time
// result    out        o_valid, one cycle        o_position_out .. o_singular_flag
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// An item with a nonzero duration runs seven serial divisions and 28 multiplies
// besides its other steps; with zero duration the normalized-time steps are
// skipped. A two-entry queue holds waiting items; busy is the queue being full.
// After reset and after each write to a valid config index the coefficient
// derivation runs before queued items are evaluated. Results cannot be stalled:
// o_valid is high for exactly one cycle.
module quintic_trajectory_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_sample_time,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_position_out,
    output logic signed [31:0] o_velocity_out,
    output logic signed [31:0] o_acceleration_out,
    output logic signed [31:0] o_jerk_out,
    output logic               o_overflow_flag,
    output logic               o_singular_flag
);

    logic               w_full;
    logic               w_avail;
    logic               w_pop;
    logic signed [31:0] w_ts;

    assign busy = w_full;

    // front: item queue
    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !w_full),
        .i_data  (i_sample_time),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_avail (w_avail),
        .o_data  (w_ts)
    );

    // back: coefficient derivation and evaluation
    qte_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_avail    (w_avail),
        .i_ts       (w_ts),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .o_pos      (o_position_out),
        .o_vel      (o_velocity_out),
        .o_acc      (o_acceleration_out),
        .o_jrk      (o_jerk_out),
        .o_ovf      (o_overflow_flag),
        .o_sing     (o_singular_flag)
    );

endmodule

@@ tb/sv/tb_quintic_trajectory_evaluator.sv @@
`timescale 1ns / 100ps

module tb_quintic_trajectory_evaluator;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int N_PHASES = 13;
    localparam int ITEMS_PER_PHASE = 100;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic signed [31:0] jrk;
        logic               ovf;
        logic               sng;
    } t_traj;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        bit          typed;
        t_traj       want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_sample_time = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [31:0] o_position_out;
    logic signed [31:0] o_velocity_out;
    logic signed [31:0] o_acceleration_out;
    logic signed [31:0] o_jerk_out;
    logic               o_overflow_flag;
    logic               o_singular_flag;

    quintic_trajectory_evaluator u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_sample_time      (i_sample_time),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_position_out     (o_position_out),
        .o_velocity_out     (o_velocity_out),
        .o_acceleration_out (o_acceleration_out),
        .o_jerk_out         (o_jerk_out),
        .o_overflow_flag    (o_overflow_flag),
        .o_singular_flag    (o_singular_flag)
    );

    always #5 i_clk = ~i_clk;

    // trajectory model state: registers and cached coefficients
    logic [31:0]        traj_reg [0:6];
    logic signed [63:0] coef [0:5];
    bit                 coef_sat;
    bit                 sat_hit;

    t_traj expected_traj_q [$];
    int    n_items = 0;
    int    n_results = 0;
    int    n_cfg = 0;
    int    n_sat = 0;
    int    n_sng = 0;
    int    n_err = 0;

    // ---- saturating fixed-point arithmetic ----
    function automatic logic signed [63:0] clamp64(input logic signed [129:0] v);
        if (v > 130'(qte_pkg::S64_MAX)) begin
            sat_hit = 1'b1;
            return qte_pkg::S64_MAX;
        end
        if (v < -130'(qte_pkg::S64_MAX)) begin
            sat_hit = 1'b1;
            return -qte_pkg::S64_MAX;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
        logic signed [129:0] v;
        v = x;
        v = v + y;
        return clamp64(v);
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
        logic signed [129:0] v;
        v = x;
        v = v - y;
        return clamp64(v);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] pack_mag(input bit neg, input logic [127:0] m);
        logic [63:0] r;
        if (m > 128'(qte_pkg::S64_MAX)) begin
            sat_hit = 1'b1;
            m = 128'(qte_pkg::S64_MAX);
        end
        r = m[63:0];
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // (x * y) >> k, magnitude rounded half away from zero
    function automatic logic signed [63:0] qmul(input logic signed [63:0] x,
                                                input logic signed [63:0] y, input int k);
        logic [127:0] p;
        p = {64'd0, abs64(x)} * {64'd0, abs64(y)};
        if (k > 0) p = (p + (128'd1 << (k - 1))) >> k;
        return pack_mag((x < 0) != (y < 0), p);
    endfunction

    // (x << k) / d, rounded half away from zero
    function automatic logic signed [63:0] qdiv(input logic signed [63:0] x, input int k,
                                                input logic [30:0] d);
        logic [127:0] n, q, r;
        n = {64'd0, abs64(x)} << k;
        q = n / d;
        r = n % d;
        if (2 * r >= d) q = q + 1;
        return pack_mag(x < 0, q);
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] v);
        return 64'($signed(v));
    endfunction

    // derive the boundary-matching coefficients from the registers
    function automatic void derive_coefs();
        logic signed [63:0] p0, v0, a0, p1, v1, a1, tt;
        logic signed [63:0] vt, at, atth, h0, h1, h2, h1t, h2t, h2tt, h2tth;
        p0 = sx(traj_reg[qte_pkg::CFG_P0]);
        v0 = sx(traj_reg[qte_pkg::CFG_V0]);
        a0 = sx(traj_reg[qte_pkg::CFG_A0]);
        p1 = sx(traj_reg[qte_pkg::CFG_P1]);
        v1 = sx(traj_reg[qte_pkg::CFG_V1]);
        a1 = sx(traj_reg[qte_pkg::CFG_A1]);
        tt = {33'd0, traj_reg[qte_pkg::CFG_DUR][30:0]};
        sat_hit = 1'b0;
        coef[0] = '0;
        coef[1] = '0;
        coef[2] = '0;
        if (tt != 0) begin
            vt    = qmul(v0, tt, qte_pkg::FRAC_BITS);
            at    = qmul(a0, tt, qte_pkg::FRAC_BITS);
            atth  = qmul(at, tt, qte_pkg::FRAC_BITS + 1);
            h0    = ssub(ssub(ssub(p1, p0), vt), atth);
            h1    = ssub(ssub(v1, v0), at);
            h2    = ssub(a1, a0);
            h1t   = qmul(h1, tt, qte_pkg::FRAC_BITS);
            h2t   = qmul(h2, tt, qte_pkg::FRAC_BITS);
            h2tt  = qmul(h2t, tt, qte_pkg::FRAC_BITS);
            h2tth = qmul(h2t, tt, qte_pkg::FRAC_BITS + 1);
            coef[0] = sadd(ssub(qmul(h0, 6, 0), qmul(h1t, 3, 0)), h2tth);
            coef[1] = ssub(sadd(qmul(h0, -15, 0), qmul(h1t, 7, 0)), h2tt);
            coef[2] = sadd(ssub(qmul(h0, 10, 0), qmul(h1t, 4, 0)), h2tth);
        end
        coef[3] = a0;
        coef[4] = v0;
        coef[5] = p0;
        coef_sat = sat_hit;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) begin
            sat_hit = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sh8000_0000) begin
            sat_hit = 1'b1;
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // position, velocity, acceleration and jerk at one sample time
    function automatic t_traj eval_traj(input logic signed [31:0] ts);
        logic signed [63:0] t, ca, cb, cc, a0, e, f;
        logic signed [63:0] t2, pos, vel, acc, jrk, s, s2, s3, s4, s5, u, w, j;
        logic [30:0]        d;
        t_traj r;
        t  = ts;
        ca = coef[0];
        cb = coef[1];
        cc = coef[2];
        a0 = coef[3];
        e  = coef[4];
        f  = coef[5];
        d  = traj_reg[qte_pkg::CFG_DUR][30:0];
        jrk = '0;
        sat_hit = coef_sat;
        t2  = qmul(t, t, qte_pkg::FRAC_BITS);
        pos = sadd(sadd(f, qmul(e, t, qte_pkg::FRAC_BITS)),
                   qmul(a0, t2, qte_pkg::FRAC_BITS + 1));
        vel = sadd(e, qmul(a0, t, qte_pkg::FRAC_BITS));
        acc = a0;
        if (d != 0) begin
            s   = qdiv(t, qte_pkg::S_FRAC, d);
            s2  = qmul(s, s, qte_pkg::S_FRAC);
            s3  = qmul(s2, s, qte_pkg::S_FRAC);
            s4  = qmul(s3, s, qte_pkg::S_FRAC);
            s5  = qmul(s4, s, qte_pkg::S_FRAC);
            pos = sadd(pos, sadd(sadd(qmul(ca, s5, qte_pkg::S_FRAC),
                                      qmul(cb, s4, qte_pkg::S_FRAC)),
                                 qmul(cc, s3, qte_pkg::S_FRAC)));
            u = sadd(sadd(qmul(qmul(ca, 5, 0), s4, qte_pkg::S_FRAC),
                          qmul(qmul(cb, 4, 0), s3, qte_pkg::S_FRAC)),
                     qmul(qmul(cc, 3, 0), s2, qte_pkg::S_FRAC));
            vel = sadd(vel, qdiv(u, qte_pkg::FRAC_BITS, d));
            w = sadd(sadd(qmul(qmul(ca, 20, 0), s3, qte_pkg::S_FRAC),
                          qmul(qmul(cb, 12, 0), s2, qte_pkg::S_FRAC)),
                     qmul(qmul(cc, 6, 0), s, qte_pkg::S_FRAC));
            acc = sadd(acc, qdiv(qdiv(w, qte_pkg::FRAC_BITS, d), qte_pkg::FRAC_BITS, d));
            j = sadd(sadd(qmul(qmul(ca, 60, 0), s2, qte_pkg::S_FRAC),
                          qmul(qmul(cb, 24, 0), s, qte_pkg::S_FRAC)),
                     qmul(cc, 6, 0));
            jrk = qdiv(qdiv(qdiv(j, qte_pkg::FRAC_BITS, d), qte_pkg::FRAC_BITS, d),
                       qte_pkg::FRAC_BITS, d);
        end
        r.pos = clamp32(pos);
        r.vel = clamp32(vel);
        r.acc = clamp32(acc);
        r.jrk = clamp32(jrk);
        r.ovf = sat_hit;
        r.sng = (d == 0);
        return r;
    endfunction

    // ---- drivers ----
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        wait (expected_traj_q.size() == 0);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= qte_pkg::CFG_DUR) begin
            traj_reg[idx] = (idx == qte_pkg::CFG_DUR) ? {1'b0, val[30:0]} : val;
            derive_coefs();
        end
        n_cfg++;
        // let the coefficient derivation finish
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_item(input logic signed [31:0] ts, input bit typed, input t_traj want,
                             input bit may_idle);
        start         <= 1'b1;
        i_sample_time <= ts;
        do @(posedge i_clk); while (busy);
        expected_traj_q.push_back(typed ? want : eval_traj(ts));
        n_items++;
        if (may_idle && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_traj got, exp_r;
        if (i_rst_n && o_valid) begin
            got = '{o_position_out, o_velocity_out, o_acceleration_out, o_jerk_out,
                    o_overflow_flag, o_singular_flag};
            n_results++;
            if (got.ovf) n_sat++;
            if (got.sng) n_sng++;
            if (expected_traj_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result: %p", got);
            end else begin
                exp_r = expected_traj_q.pop_front();
                if (got.pos !== exp_r.pos || got.vel !== exp_r.vel || got.acc !== exp_r.acc ||
                    got.jrk !== exp_r.jrk || got.ovf !== exp_r.ovf || got.sng !== exp_r.sng)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch at result %0d: expected %p got %p",
                                 n_results, exp_r, got);
                end
            end
        end
    end

    function automatic t_row cfg_row(input logic [2:0] idx, input logic [31:0] val);
        return '{ROW_CFG, idx, val, 1'b0, '0};
    endfunction

    function automatic t_row item_row(input logic [31:0] ts);
        return '{ROW_ITEM, 3'd0, ts, 1'b0, '0};
    endfunction

    function automatic t_row item_row_exp(input logic [31:0] ts, input t_traj want);
        return '{ROW_ITEM, 3'd0, ts, 1'b1, want};
    endfunction

    // realistic or full-range register values
    function automatic logic [31:0] pick_reg(input logic [2:0] idx, input int mode);
        if (mode == 1) return $urandom;
        case (idx)
            qte_pkg::CFG_P0, qte_pkg::CFG_P1:
                return 32'($urandom_range(0, 200 * 65536)) - 32'(100 * 65536);
            qte_pkg::CFG_V0, qte_pkg::CFG_V1:
                return 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536);
            qte_pkg::CFG_A0, qte_pkg::CFG_A1:
                return 32'($urandom_range(0, 10 * 65536)) - 32'(5 * 65536);
            default:
                return 32'($urandom_range(3277, 10 * 65536));
        endcase
    endfunction

    // ---- stimulus ----
    initial begin
        t_row        rows [$];
        t_traj       zero_r, sng_r;
        int          mode;
        logic [31:0] dur;
        logic [31:0] ts;

        for (int i = 0; i < 7; i++) traj_reg[i] = '0;
        traj_reg[qte_pkg::CFG_DUR] = {1'b0, qte_pkg::DUR_RESET};
        derive_coefs();

        zero_r = '0;
        sng_r  = '0;
        sng_r.sng = 1'b1;

        // after reset every coefficient is zero; zero duration gives singular zeros
        rows.push_back(item_row_exp(32'd0, zero_r));
        rows.push_back(item_row(32'h7FFF_FFFF));
        rows.push_back(item_row(32'h8000_0000));
        rows.push_back(item_row(32'h0001_0000));
        rows.push_back(cfg_row(qte_pkg::CFG_DUR, 32'd0));
        rows.push_back(item_row_exp(32'h8000_0000, sng_r));
        rows.push_back(item_row_exp(32'h7FFF_FFFF, sng_r));
        // nonzero start state with singular duration still evaluates the t terms
        rows.push_back(cfg_row(qte_pkg::CFG_P0, 32'h0003_0000));
        rows.push_back(cfg_row(qte_pkg::CFG_V0, 32'hFFFF_8000));
        rows.push_back(cfg_row(qte_pkg::CFG_A0, 32'h0002_0000));
        rows.push_back(item_row(32'h0002_0000));
        // ordinary trajectory, inside and outside the duration
        rows.push_back(cfg_row(qte_pkg::CFG_P1, 32'h000A_0000));
        rows.push_back(cfg_row(qte_pkg::CFG_V1, 32'h0001_0000));
        rows.push_back(cfg_row(qte_pkg::CFG_A1, 32'hFFFF_0000));
        rows.push_back(cfg_row(qte_pkg::CFG_DUR, 32'h8002_0000));   // top bit dropped
        rows.push_back(item_row(32'h0001_0000));
        rows.push_back(item_row(32'h0002_0000));
        rows.push_back(item_row(32'hFFFF_0000));
        rows.push_back(item_row(32'h0006_0000));
        // register index past the end is ignored
        rows.push_back(cfg_row(CFG_UNUSED, 32'hFFFF_FFFF));
        rows.push_back(item_row(32'h0000_8000));
        // smallest and largest durations, extreme boundary values
        rows.push_back(cfg_row(qte_pkg::CFG_DUR, 32'd1));
        rows.push_back(item_row(32'd1));
        rows.push_back(cfg_row(qte_pkg::CFG_P1, 32'h8000_0000));
        rows.push_back(cfg_row(qte_pkg::CFG_A1, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(qte_pkg::CFG_DUR, 32'h7FFF_FFFF));
        rows.push_back(item_row(32'h7FFF_FFFF));
        rows.push_back(item_row(32'h4000_0000));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                start <= 1'b0;
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_item(rows[i].val, rows[i].typed, rows[i].want, 1'b0);
            end
        end

        // random phases: a fresh trajectory each, then a batch of sample times
        for (int ph = 0; ph < N_PHASES; ph++) begin
            start <= 1'b0;
            mode = (ph % 4 == 2) ? 1 : 0;
            for (int r = 0; r <= qte_pkg::CFG_DUR; r++)
                write_reg(3'(r), pick_reg(3'(r), mode));
            if (ph == 5) write_reg(qte_pkg::CFG_DUR, 32'd0);
            dur = traj_reg[qte_pkg::CFG_DUR];
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 9) == 0 || dur == 0)
                    ts = $urandom;
                else
                    ts = 32'($urandom_range(0, dur + dur / 5)) - dur / 10;
                // phase 3 runs without any gaps
                send_item(ts, 1'b0, '0, ph != 3);
            end
        end
        start <= 1'b0;

        wait (expected_traj_q.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("%0d sample times over %0d register writes; %0d results, %0d saturated, %0d singular",
                 n_items, n_cfg, n_results, n_sat, n_sng);
        $display("%0d mismatches", n_err);
        if (n_err == 0 && expected_traj_q.size() == 0)
            $display("tb_quintic_trajectory_evaluator passed");
        else
            $display("tb_quintic_trajectory_evaluator failed");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb_quintic_trajectory_evaluator failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/qte_pkg.sv
src/qte_fifo.sv
src/qte_mul.sv
src/qte_div.sv
src/qte_engine.sv
src/quintic_trajectory_evaluator.sv
tb/sv/tb_quintic_trajectory_evaluator.sv
